[src/svm_pkg.sv]
`default_nettype none

package svm_pkg;

    // Voice table and sample memory dimensions.
    localparam int VOICES       = 30;
    localparam int SAMPLE_WORDS = 65536;
    localparam int SLOT_W       = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MEM_AW       = $clog2(SAMPLE_WORDS);

    // Field widths of one transaction on each side.
    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 17;
    localparam int IN_TDATA_W  = ((ADDR_W + SAMPLE_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    // Request codes carried in the input tuser.
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUEUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    // Status codes carried in the output tuser.
    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Control of the shared saturating accumulator.
    typedef struct packed {
        logic clr;
        logic add;
    } t_acc_ctl;

endpackage

`default_nettype wire

[src/svm_sat_acc.sv]
`default_nettype none

// Shared saturating accumulator: adds one signed sample per cycle in which add
// is set and clamps the running sum to the signed 16-bit range after each add.
module svm_sat_acc (
    input  wire                                 i_clk,
    input  wire  svm_pkg::t_acc_ctl             i_ctl,
    input  wire  logic signed [svm_pkg::SAMPLE_W-1:0] i_sample,
    output logic signed [svm_pkg::SAMPLE_W-1:0] o_acc
);

    localparam int W = svm_pkg::SAMPLE_W;

    logic signed [W-1:0] r_acc;
    logic signed [W-1:0] n_acc;
    logic signed [W:0]   sum;

    // One wide add, then clamp when the carry and sign bits disagree.
    always_comb begin
        sum = {r_acc[W-1], r_acc} + {i_sample[W-1], i_sample};
        if (sum[W] != sum[W-1]) begin
            n_acc = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            n_acc = sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.add) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

[src/saturating_voice_mixer.sv]
`default_nettype none

// Saturating PCM voice mixer. Each input transaction is one request, chosen by
// tuser: load writes a signed word into the 64K-word sample memory, queue
// places a sound (start address, length) into the lowest free voice slot, and
// tick mixes the current sample of every active voice in slot order with
// clamping after each addition, then advances the voices. Every request
// returns exactly one output transaction: the mix on tick (zero otherwise)
// and a status flag in tuser that is set when a queue finds every slot busy.
// The block takes one request at a time. A load, an unused code or a queue of
// zero length goes straight to the done state, a queue scans the slots from
// the lowest for a free one, and a tick walks every slot; an active voice
// passes through a read state and then an accumulate state, because its word
// comes from the single registered read port of the sample memory before the
// shared saturating adder takes it. A result that waits on the output side
// holds the block in its done state. Words never loaded read as unknown values.
module saturating_voice_mixer (
    input  wire  i_clk,
    input  wire  i_rst_n,
    // Request side.
    input  wire  i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // tdata: address[15:0], sample_value[31:16], length[48:32], zero pad.
    input  wire  [svm_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: req_type[1:0].
    input  wire  [svm_pkg::REQ_W-1:0] i_s_axis_tuser,
    // Result side.
    output logic o_m_axis_tvalid,
    input  wire  i_m_axis_tready,
    // tdata: mixed_sample[15:0].
    output logic [svm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: status[0].
    output logic o_m_axis_tuser
);

    localparam int VOICES   = svm_pkg::VOICES;
    localparam int SLOT_W   = svm_pkg::SLOT_W;
    localparam int MEM_AW   = svm_pkg::MEM_AW;
    localparam int ADDR_W   = svm_pkg::ADDR_W;
    localparam int SAMPLE_W = svm_pkg::SAMPLE_W;
    localparam int LEN_W    = svm_pkg::LEN_W;
    localparam int OUT_TDATA_W = svm_pkg::OUT_TDATA_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(VOICES - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QSCAN = 3'd1;
    localparam logic [2:0] ST_TREAD = 3'd2;
    localparam logic [2:0] ST_TACC  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [SLOT_W-1:0] r_slot;
    logic [svm_pkg::REQ_W-1:0] r_req;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic r_status;

    logic [VOICES-1:0] r_voice_valid;
    logic [ADDR_W-1:0] r_voice_addr [VOICES];
    logic [LEN_W-1:0]  r_voice_rem  [VOICES];

    logic [SAMPLE_W-1:0] r_mem [svm_pkg::SAMPLE_WORDS];
    logic [SAMPLE_W-1:0] r_rd_data;

    logic r_out_valid;
    logic [SAMPLE_W-1:0] r_out_mix;
    logic r_out_status;

    logic s_ack;
    logic out_free;
    logic last_slot;
    logic slot_valid;
    logic [ADDR_W-1:0]   in_addr;
    logic [SAMPLE_W-1:0] in_sample;
    logic [LEN_W-1:0]    in_len;
    svm_pkg::t_acc_ctl   acc_ctl;
    logic signed [SAMPLE_W-1:0] acc;

    assign in_addr   = i_s_axis_tdata[ADDR_W-1:0];
    assign in_sample = i_s_axis_tdata[ADDR_W +: SAMPLE_W];
    assign in_len    = i_s_axis_tdata[ADDR_W + SAMPLE_W +: LEN_W];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_ack      = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign last_slot  = (r_slot == LAST_SLOT);
    assign slot_valid = r_voice_valid[r_slot];

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_ack) begin
                    priority if (i_s_axis_tuser == svm_pkg::REQ_QUEUE) begin
                        n_state = (in_len == '0) ? ST_DONE : ST_QSCAN;
                    end else if (i_s_axis_tuser == svm_pkg::REQ_TICK) begin
                        n_state = ST_TREAD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_QSCAN: begin
                if (!slot_valid || last_slot) begin
                    n_state = ST_DONE;
                end
            end
            ST_TREAD: begin
                if (slot_valid) begin
                    n_state = ST_TACC;
                end else if (last_slot) begin
                    n_state = ST_DONE;
                end
            end
            ST_TACC: begin
                n_state = last_slot ? ST_DONE : ST_TREAD;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers: state, slot counter, status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_slot   <= '0;
            r_status <= svm_pkg::STATUS_DONE;
        end else begin
            r_state <= n_state;
            if (s_ack) begin
                r_slot   <= '0;
                r_status <= svm_pkg::STATUS_DONE;
            end else if (r_state == ST_QSCAN) begin
                if (slot_valid && last_slot) begin
                    r_status <= svm_pkg::STATUS_FULL;
                end else if (slot_valid) begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end else if ((r_state == ST_TREAD && !slot_valid && !last_slot)
                         || (r_state == ST_TACC && !last_slot)) begin
                r_slot <= r_slot + SLOT_W'(1);
            end
        end
    end

    // Request payload latch.
    always_ff @(posedge i_clk) begin
        if (s_ack) begin
            r_req  <= i_s_axis_tuser;
            r_addr <= in_addr;
            r_len  <= in_len;
        end
    end

    // Voice valid bits: set by a queue, cleared when a voice runs out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice_valid <= '0;
        end else if (r_state == ST_QSCAN && !slot_valid) begin
            r_voice_valid[r_slot] <= 1'b1;
        end else if (r_state == ST_TREAD && slot_valid
                     && r_voice_rem[r_slot] <= LEN_W'(1)) begin
            r_voice_valid[r_slot] <= 1'b0;
        end
    end

    // Voice address and remaining count of the slot under the counter.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_QSCAN && !slot_valid) begin
            r_voice_addr[r_slot] <= r_addr;
            r_voice_rem[r_slot]  <= r_len;
        end else if (r_state == ST_TREAD && slot_valid) begin
            r_voice_addr[r_slot] <= r_voice_addr[r_slot] + ADDR_W'(1);
            if (r_voice_rem[r_slot] <= LEN_W'(1)) begin
                r_voice_rem[r_slot] <= '0;
            end else begin
                r_voice_rem[r_slot] <= r_voice_rem[r_slot] - LEN_W'(1);
            end
        end
    end

    // Sample memory: written on load, read once per active voice on tick.
    always_ff @(posedge i_clk) begin
        if (s_ack && i_s_axis_tuser == svm_pkg::REQ_LOAD) begin
            r_mem[in_addr[MEM_AW-1:0]] <= in_sample;
        end
        if (r_state == ST_TREAD && slot_valid) begin
            r_rd_data <= r_mem[r_voice_addr[r_slot][MEM_AW-1:0]];
        end
    end

    // Shared saturating adder.
    assign acc_ctl.clr = s_ack;
    assign acc_ctl.add = (r_state == ST_TACC);

    svm_sat_acc u_acc (
        .i_clk    (i_clk),
        .i_ctl    (acc_ctl),
        .i_sample (r_rd_data),
        .o_acc    (acc)
    );

    // Output register: parts the result side from the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_mix    <= acc;
            r_out_status <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_mix);
    assign o_m_axis_tuser  = r_out_status;

`ifndef ASSERT_OFF
    // An accepted request always holds off the next one: ready is low in the cycle after it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ack |=> !o_s_axis_tready)
        else $error("request side ready right after an accepted request");

    // A refused queue is only reported when every slot is taken.
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_status == svm_pkg::STATUS_FULL)
            |-> (&r_voice_valid && r_req == svm_pkg::REQ_QUEUE))
        else $error("queue refused while a slot was free");

    // Requests other than tick finish with an empty mix.
    a_zero_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_req != svm_pkg::REQ_TICK) |-> (acc == '0))
        else $error("non-tick request produced a nonzero mix");

    // The adder only runs during a tick and right after a memory read.
    a_acc_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TACC)
            |-> (r_req == svm_pkg::REQ_TICK && $past(r_state) == ST_TREAD))
        else $error("accumulation outside a tick walk");
`endif

endmodule

`default_nettype wire
